// ===== hw/rtl/x64_insn_length_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// x64 instruction length decoder assertion macros
// Shorthand for the concurrent checks of the decoder core. The macros sample
// on the rising edge of clk and are off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef X64_INSN_LENGTH_DECODER_CORE_DEFINES_SVH
`define X64_INSN_LENGTH_DECODER_CORE_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define X64ILD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define X64ILD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/x64ild_pkg.sv =====
// ----------------------------------------------------------------------------
// x64 instruction length decoder package
// Phase and immediate codes, opcode constants and byte classifiers.
// ----------------------------------------------------------------------------
package x64ild_pkg;

	// Default saturation point of the byte count
	localparam int unsigned MAX_LENGTH_DEF = 31;

	// Field widths
	localparam int unsigned LEN_W = 5;

	// Decode phases
	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_OPCODE = 3'd1;
	localparam logic [2:0] PH_OP2    = 3'd2;
	localparam logic [2:0] PH_MODRM  = 3'd3;
	localparam logic [2:0] PH_SIB    = 3'd4;
	localparam logic [2:0] PH_TAIL   = 3'd5;

	// Immediate kinds after ModRM
	localparam logic [1:0] IMM_NONE = 2'd0;
	localparam logic [1:0] IMM_8    = 2'd1;
	localparam logic [1:0] IMM_32   = 2'd2;

	// Opcode constants
	localparam logic [3:0] REX_HI_NIBBLE  = 4'h4;
	localparam logic [3:0] PUSHPOP_NIBBLE = 4'h5;
	localparam logic [7:0] OP_ESCAPE_0F   = 8'h0F;
	localparam logic [7:0] OP_RET         = 8'hC3;
	localparam logic [7:0] OP_NOP         = 8'h90;
	localparam logic [7:0] OP_INT3        = 8'hCC;
	localparam logic [7:0] OP_GRP1_IB     = 8'h83;
	localparam logic [7:0] OP_GRP1_ID     = 8'h81;
	localparam logic [7:0] OP_MOV_BASE    = 8'h88;
	localparam logic [7:0] OP_LEA         = 8'h8D;
	localparam logic [7:0] OP_MOV_RI32    = 8'hB8;
	localparam logic [7:0] OP_MOV_RI8     = 8'hB0;

	// Bytes taken by each immediate and displacement kind
	localparam logic [3:0] IMM8_BYTES  = 4'd1;
	localparam logic [3:0] IMM32_BYTES = 4'd4;
	localparam logic [3:0] IMM64_BYTES = 4'd8;
	localparam logic [3:0] DISP8_BYTES = 4'd1;
	localparam logic [3:0] DISP32_BYTES = 4'd4;

	// Legacy prefix bytes
	function automatic logic is_legacy_prefix(input logic [7:0] b);
		return b == 8'h66 || b == 8'h67 || b == 8'hF0 || b == 8'hF2 ||
			b == 8'hF3 || b == 8'h2E || b == 8'h36 || b == 8'h3E ||
			b == 8'h26 || b == 8'h64 || b == 8'h65;
	endfunction

	// ALU forms with a ModRM byte and no immediate
	function automatic logic is_alu_modrm(input logic [7:0] b);
		return b == 8'h31 || b == 8'h33 || b == 8'h85 || b == 8'h29 ||
			b == 8'h2B || b == 8'h39 || b == 8'h3B || b == 8'h09 ||
			b == 8'h0B || b == 8'h21 || b == 8'h23;
	endfunction

endpackage

// ===== hw/rtl/x64_insn_length_decoder_core.sv =====
// ----------------------------------------------------------------------------
// x64 instruction length decoder core
// Byte-serial length decode of x64 prologue code: prefixes, REX, opcode,
// ModRM, SIB, displacement and immediate, one result per instruction.
// ----------------------------------------------------------------------------
// Takes one code word per cycle, every cycle, as long as out_stall is low.
// Each accepted byte lands in an input register and is decoded in one pass
// against the decode state; unless the sink stalls, the pass over the
// instruction's last byte loads the result register. in_stall rises only
// while a byte waits in the input register and the result register holds a
// word that the sink stalls. restart drops any partial decode with no result.
// Length saturates at MAX_LENGTH and reads at most 31.
// ----------------------------------------------------------------------------
module x64_insn_length_decoder_core #(
	parameter int unsigned MAX_LENGTH = x64ild_pkg::MAX_LENGTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Code byte channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    code_byte,
	input  logic                          restart,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [x64ild_pkg::LEN_W-1:0]  insn_length,
	output logic                          rip_relative,
	output logic [x64ild_pkg::LEN_W-1:0]  disp_offset,
	output logic                          decode_error
);
	import x64ild_pkg::*;

	`include "x64_insn_length_decoder_core_defines.svh"

	localparam int unsigned CW = $clog2(MAX_LENGTH + 1);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       restart_s1;

	// Decode state
	logic [2:0]    phase_q;
	logic [CW-1:0] cnt_q;
	logic          rexw_q;
	logic [1:0]    immk_q;
	logic [3:0]    rem_q;
	logic          rip_q;
	logic [CW-1:0] dpos_q;

	// Result register
	logic              out_valid_q;
	logic [LEN_W-1:0]  len_q;
	logic              rip_out_q;
	logic [LEN_W-1:0]  disp_q;
	logic              err_q;

	// Decode pass variables
	logic [2:0]    ph;
	logic [CW-1:0] cnt;
	logic          rexw;
	logic [1:0]    immk;
	logic [3:0]    rem;
	logic          rip;
	logic [CW-1:0] dpos;
	logic          emit;
	logic          err;
	logic          take_op;
	logic [1:0]    mod_f;
	logic [2:0]    rm_f;
	logic [3:0]    imm_bytes;
	logic [3:0]    disp_bytes;
	logic          sib;
	logic [CW+4:0] cnt_wide;
	logic [CW+4:0] dpos_wide;
	logic [LEN_W-1:0] len_cap;
	logic [LEN_W-1:0] dpos_cap;

	logic adv;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	// Input register: refills whenever it is empty or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1    <= code_byte;
			restart_s1 <= restart;
		end
	end

	// One decode pass over the registered byte
	always_comb begin
		ph   = restart_s1 ? PH_START : phase_q;
		cnt  = restart_s1 ? '0 : cnt_q;
		rexw = restart_s1 ? 1'b0 : rexw_q;
		immk = restart_s1 ? IMM_NONE : immk_q;
		rem  = restart_s1 ? 4'd0 : rem_q;
		rip  = restart_s1 ? 1'b0 : rip_q;
		dpos = restart_s1 ? '0 : dpos_q;
		emit = 1'b0;
		err  = 1'b0;
		take_op    = 1'b0;
		mod_f      = byte_s1[7:6];
		rm_f       = byte_s1[2:0];
		imm_bytes  = 4'd0;
		disp_bytes = 4'd0;
		sib        = 1'b0;

		if (cnt < CW'(MAX_LENGTH)) begin
			cnt = cnt + CW'(1);
		end

		case (ph)
			PH_OPCODE: begin
				take_op = 1'b1;
			end
			PH_OP2: begin
				if (byte_s1 == OP_GRP1_IB) begin
					immk = IMM_8;
				end else if (byte_s1 == OP_GRP1_ID) begin
					immk = IMM_32;
				end else begin
					immk = IMM_NONE;
				end
				ph = PH_MODRM;
			end
			PH_MODRM: begin
				case (immk)
					IMM_8:   imm_bytes = IMM8_BYTES;
					IMM_32:  imm_bytes = IMM32_BYTES;
					default: imm_bytes = 4'd0;
				endcase
				if (mod_f == 2'd0 && rm_f == 3'd5) begin
					rip        = 1'b1;
					dpos       = cnt;
					disp_bytes = DISP32_BYTES;
				end else if (mod_f == 2'd0 && rm_f == 3'd4) begin
					sib = 1'b1;
				end else if (mod_f == 2'd1) begin
					sib        = (rm_f == 3'd4);
					disp_bytes = DISP8_BYTES;
				end else if (mod_f == 2'd2) begin
					sib        = (rm_f == 3'd4);
					disp_bytes = DISP32_BYTES;
				end
				rem = disp_bytes + imm_bytes;
				if (sib) begin
					ph = PH_SIB;
				end else if (rem == 4'd0) begin
					emit = 1'b1;
				end else begin
					ph = PH_TAIL;
				end
			end
			PH_SIB: begin
				if (rem == 4'd0) begin
					emit = 1'b1;
				end else begin
					ph = PH_TAIL;
				end
			end
			PH_TAIL: begin
				if (rem != 4'd0) begin
					rem = rem - 4'd1;
				end
				if (rem == 4'd0) begin
					emit = 1'b1;
				end
			end
			default: begin
				// Expecting the first byte: prefixes, then an optional REX
				ph = PH_START;
				if (is_legacy_prefix(byte_s1)) begin
					ph = PH_START;
				end else if (byte_s1[7:4] == REX_HI_NIBBLE) begin
					rexw = byte_s1[3];
					ph   = PH_OPCODE;
				end else begin
					take_op = 1'b1;
				end
			end
		endcase

		// Opcode classification
		if (take_op) begin
			if (byte_s1 == OP_ESCAPE_0F) begin
				ph = PH_OP2;
			end else if (byte_s1[7:4] == PUSHPOP_NIBBLE || byte_s1 == OP_RET ||
					byte_s1 == OP_NOP || byte_s1 == OP_INT3) begin
				emit = 1'b1;
			end else if (byte_s1[7:2] == OP_MOV_BASE[7:2] || byte_s1 == OP_LEA ||
					is_alu_modrm(byte_s1)) begin
				immk = IMM_NONE;
				ph   = PH_MODRM;
			end else if (byte_s1 == OP_GRP1_IB) begin
				immk = IMM_8;
				ph   = PH_MODRM;
			end else if (byte_s1 == OP_GRP1_ID) begin
				immk = IMM_32;
				ph   = PH_MODRM;
			end else if (byte_s1[7:3] == OP_MOV_RI32[7:3]) begin
				rem = rexw ? IMM64_BYTES : IMM32_BYTES;
				ph  = PH_TAIL;
			end else if (byte_s1[7:3] == OP_MOV_RI8[7:3]) begin
				rem = IMM8_BYTES;
				ph  = PH_TAIL;
			end else begin
				emit = 1'b1;
				err  = 1'b1;
			end
		end

		// Report values capped to the 5-bit fields
		cnt_wide  = {5'd0, cnt};
		dpos_wide = {5'd0, dpos};
		len_cap   = (cnt_wide > (CW+5)'(31)) ? 5'd31 : cnt_wide[LEN_W-1:0];
		dpos_cap  = (dpos_wide > (CW+5)'(31)) ? 5'd31 : dpos_wide[LEN_W-1:0];
	end

	// Decode state update; a finished instruction clears everything
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			cnt_q   <= '0;
			rexw_q  <= 1'b0;
			immk_q  <= IMM_NONE;
			rem_q   <= 4'd0;
			rip_q   <= 1'b0;
			dpos_q  <= '0;
		end else if (adv) begin
			if (emit) begin
				phase_q <= PH_START;
				cnt_q   <= '0;
				rexw_q  <= 1'b0;
				immk_q  <= IMM_NONE;
				rem_q   <= 4'd0;
				rip_q   <= 1'b0;
				dpos_q  <= '0;
			end else begin
				phase_q <= ph;
				cnt_q   <= cnt;
				rexw_q  <= rexw;
				immk_q  <= immk;
				rem_q   <= rem;
				rip_q   <= rip;
				dpos_q  <= dpos;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (adv && emit) begin
			len_q     <= len_cap;
			rip_out_q <= !err && rip;
			disp_q    <= (!err && rip) ? dpos_cap : 5'd0;
			err_q     <= err;
		end
	end

	assign out_valid    = out_valid_q;
	assign insn_length  = len_q;
	assign rip_relative = rip_out_q;
	assign disp_offset  = disp_q;
	assign decode_error = err_q;

	// Checks
	`X64ILD_ASSERT_NOW(a_err_no_rip, out_valid && decode_error, !rip_relative && disp_offset == 5'd0, "error word carries RIP-relative data")
	`X64ILD_ASSERT_NOW(a_disp_in_range, out_valid && rip_relative, disp_offset >= 5'd2 && disp_offset <= insn_length, "disp32 position outside instruction")
	`X64ILD_ASSERT_NOW(a_stall_cause, in_stall, out_valid_q && out_stall && valid_s1, "input stalled without a blocked result")
	`X64ILD_ASSERT_NOW(a_tail_nonzero, phase_q == PH_TAIL, rem_q != 4'd0, "tail phase with no bytes left")
	`X64ILD_ASSERT_NEXT(a_emit_loads, adv && emit, out_valid_q, "finished instruction not presented")

endmodule

// ===== sim/x64_insn_length_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// x64 instruction length decoder core testbench
// Streams code bytes into the decoder and checks each finished-instruction
// word against a byte-serial predictor kept in a small scoreboard class.
// Directed prologue code comes first. It is followed by random well-formed
// instructions, truncated ones, noise and long prefix runs. Both channels
// idle at random, and the sink holds off once for a long stretch.
// ----------------------------------------------------------------------------
module x64_insn_length_decoder_core_tb;
	import x64ild_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 6;
	localparam int ITEM_TARGET    = 450;
	localparam int CALM_ITEMS     = 70;
	localparam int LONG_HOLD      = 40;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 1000;

	// ModRM / SIB field values
	localparam logic [1:0] MOD_INDIRECT = 2'd0;
	localparam logic [1:0] MOD_DISP8    = 2'd1;
	localparam logic [1:0] MOD_DISP32   = 2'd2;
	localparam logic [2:0] RM_SIB       = 3'd4;
	localparam logic [2:0] RM_DISP32    = 3'd5;
	localparam logic [2:0] SIB_NO_BASE  = 3'd5;
	localparam int NUM_PREFIXES = 11;
	localparam int NUM_ALU_OPS  = 11;

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic             rip;
		logic [LEN_W-1:0] disp;
		logic             err;
	} insn_result_t;

	// Legacy prefix table
	function automatic logic [7:0] prefix_byte(input int idx);
		case (idx)
			0: return 8'h66;
			1: return 8'h67;
			2: return 8'hF0;
			3: return 8'hF2;
			4: return 8'hF3;
			5: return 8'h2E;
			6: return 8'h36;
			7: return 8'h3E;
			8: return 8'h26;
			9: return 8'h64;
			default: return 8'h65;
		endcase
	endfunction

	// ALU opcodes taking ModRM and no immediate
	function automatic logic [7:0] alu_byte(input int idx);
		case (idx)
			0: return 8'h31;
			1: return 8'h33;
			2: return 8'h85;
			3: return 8'h29;
			4: return 8'h2B;
			5: return 8'h39;
			6: return 8'h3B;
			7: return 8'h09;
			8: return 8'h0B;
			9: return 8'h21;
			default: return 8'h23;
		endcase
	endfunction

	// Tracks the decode of the byte stream and holds the words still owed
	class insn_checker;
		logic [2:0]       phase;
		logic [LEN_W-1:0] count;
		logic             wide;
		logic [1:0]       imm_sel;
		logic [3:0]       remaining;
		logic             rip;
		logic [LEN_W-1:0] disp_pos;
		insn_result_t     pending_insns[$];
		int               errors;

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			phase = PH_START;
			count = '0;
			wide = 1'b0;
			imm_sel = IMM_NONE;
			remaining = '0;
			rip = 1'b0;
			disp_pos = '0;
		endfunction

		function bit idle();
			return phase == PH_START && count == 0;
		endfunction

		function bit is_prefix(input logic [7:0] b);
			for (int i = 0; i < NUM_PREFIXES; i++)
				if (b == prefix_byte(i))
					return 1'b1;
			return 1'b0;
		endfunction

		function bit is_alu(input logic [7:0] b);
			for (int i = 0; i < NUM_ALU_OPS; i++)
				if (b == alu_byte(i))
					return 1'b1;
			return 1'b0;
		endfunction

		// Instruction done: owe one word, then start afresh
		function void finish_insn(input logic err);
			insn_result_t r;
			r.length = count;
			r.rip = err ? 1'b0 : rip;
			r.disp = (err || !rip) ? '0 : disp_pos;
			r.err = err;
			pending_insns.push_back(r);
			clear();
		endfunction

		function void take_opcode(input logic [7:0] b);
			if (b == OP_ESCAPE_0F) begin
				phase = PH_OP2;
			end else if (b[7:4] == PUSHPOP_NIBBLE || b == OP_RET || b == OP_NOP ||
					b == OP_INT3) begin
				finish_insn(1'b0);
			end else if ((b >= OP_MOV_BASE && b <= OP_MOV_BASE + 3) || b == OP_LEA ||
					is_alu(b)) begin
				imm_sel = IMM_NONE;
				phase = PH_MODRM;
			end else if (b == OP_GRP1_IB || b == OP_GRP1_ID) begin
				imm_sel = (b == OP_GRP1_IB) ? IMM_8 : IMM_32;
				phase = PH_MODRM;
			end else if (b[7:3] == OP_MOV_RI32[7:3]) begin
				remaining = wide ? IMM64_BYTES : IMM32_BYTES;
				phase = PH_TAIL;
			end else if (b[7:3] == OP_MOV_RI8[7:3]) begin
				remaining = IMM8_BYTES;
				phase = PH_TAIL;
			end else begin
				finish_insn(1'b1);
			end
		endfunction

		function void take_modrm(input logic [7:0] b);
			logic [1:0] md;
			logic [2:0] rm;
			logic [3:0] imm_n;
			logic [3:0] disp_n;
			bit         sib;
			md = b[7:6];
			rm = b[2:0];
			imm_n = (imm_sel == IMM_8) ? IMM8_BYTES : (imm_sel == IMM_32) ? IMM32_BYTES : 4'd0;
			disp_n = 4'd0;
			sib = 1'b0;
			if (md == MOD_INDIRECT && rm == RM_DISP32) begin
				rip = 1'b1;
				disp_pos = count;
				disp_n = DISP32_BYTES;
			end else if (md == MOD_INDIRECT && rm == RM_SIB) begin
				sib = 1'b1;
			end else if (md == MOD_DISP8) begin
				sib = (rm == RM_SIB);
				disp_n = DISP8_BYTES;
			end else if (md == MOD_DISP32) begin
				sib = (rm == RM_SIB);
				disp_n = DISP32_BYTES;
			end
			remaining = disp_n + imm_n;
			if (sib)
				phase = PH_SIB;
			else if (remaining == 0)
				finish_insn(1'b0);
			else
				phase = PH_TAIL;
		endfunction

		// One accepted code word
		function void note_byte(input logic [7:0] b, input logic rst);
			if (rst)
				clear();
			if (count < MAX_LENGTH_DEF)
				count++;
			case (phase)
				PH_OPCODE: take_opcode(b);
				PH_OP2: begin
					imm_sel = (b == OP_GRP1_IB) ? IMM_8 : (b == OP_GRP1_ID) ? IMM_32 : IMM_NONE;
					phase = PH_MODRM;
				end
				PH_MODRM: take_modrm(b);
				PH_SIB: begin
					if (remaining == 0)
						finish_insn(1'b0);
					else
						phase = PH_TAIL;
				end
				PH_TAIL: begin
					if (remaining > 0)
						remaining--;
					if (remaining == 0)
						finish_insn(1'b0);
				end
				default: begin
					phase = PH_START;
					if (!is_prefix(b)) begin
						if (b[7:4] == REX_HI_NIBBLE) begin
							wide = b[3];
							phase = PH_OPCODE;
						end else begin
							take_opcode(b);
						end
					end
				end
			endcase
		endfunction

		function void compare_field(input string field, input logic [4:0] want,
				input logic [4:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		// One accepted result word
		function void check_result(input logic [LEN_W-1:0] len, input logic rip_v,
				input logic [LEN_W-1:0] disp, input logic err);
			insn_result_t want;
			if (pending_insns.size() == 0) begin
				$error("result with no instruction pending: insn_length %0d", len);
				errors++;
				return;
			end
			want = pending_insns.pop_front();
			compare_field("insn_length", want.length, len);
			compare_field("rip_relative", 5'(want.rip), 5'(rip_v));
			compare_field("disp_offset", want.disp, disp);
			compare_field("decode_error", 5'(want.err), 5'(err));
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [7:0]       code_byte;
	logic             restart;
	logic             out_valid;
	logic             out_stall;
	logic [LEN_W-1:0] insn_length;
	logic             rip_relative;
	logic [LEN_W-1:0] disp_offset;
	logic             decode_error;

	insn_checker sb = new();
	int          sent_count = 0;
	int          quiet_cycles = 0;
	bit          quiet_tail = 1'b0;
	bit          hold_req = 1'b0;
	bit          next_restart = 1'b0;

	x64_insn_length_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.code_byte    (code_byte),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.insn_length  (insn_length),
		.rip_relative (rip_relative),
		.disp_offset  (disp_offset),
		.decode_error (decode_error)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Offer one code word and wait until it is taken
	task automatic send_byte(input logic [7:0] b, input logic rst);
		if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid <= 1'b1;
		code_byte <= b;
		restart <= rst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_byte(b, rst);
		sent_count++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_opcode();
		case ($urandom_range(0, 6))
			0: begin
				case ($urandom_range(0, 3))
					0: return {PUSHPOP_NIBBLE, 4'($urandom_range(0, 15))};
					1: return OP_RET;
					2: return OP_NOP;
					default: return OP_INT3;
				endcase
			end
			1: return OP_MOV_RI8 + 8'($urandom_range(0, 7));
			2: return OP_MOV_RI32 + 8'($urandom_range(0, 7));
			3: return $urandom_range(0, 4) == 0 ? OP_LEA : OP_MOV_BASE + 8'($urandom_range(0, 3));
			4: return alu_byte($urandom_range(0, NUM_ALU_OPS - 1));
			5: return $urandom_range(0, 1) ? OP_GRP1_IB : OP_GRP1_ID;
			default: return OP_ESCAPE_0F;
		endcase
	endfunction

	function automatic logic [7:0] pick_op2();
		case ($urandom_range(0, 2))
			0: return OP_GRP1_IB;
			1: return OP_GRP1_ID;
			default: return 8'($urandom);
		endcase
	endfunction

	// ModRM with RIP-relative and SIB forms made common
	function automatic logic [7:0] pick_modrm();
		logic [2:0] rm;
		case ($urandom_range(0, 2))
			0: rm = RM_DISP32;
			1: rm = RM_SIB;
			default: rm = 3'($urandom_range(0, 7));
		endcase
		return {2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rm};
	endfunction

	function automatic logic [7:0] pick_sib();
		logic [2:0] base;
		base = $urandom_range(0, 1) ? SIB_NO_BASE : 3'($urandom_range(0, 7));
		return {5'($urandom_range(0, 31)), base};
	endfunction

	// Prefixes, optional REX, opcode, ModRM and SIB, then random tail bytes
	// until the instruction closes; a cut-short one leaves the rest to restart
	task automatic send_insn(input int n_prefix, input bit cut_short);
		logic [7:0] op;
		logic       rst;
		rst = next_restart || ($urandom_range(0, 7) == 0);
		next_restart = 1'b0;
		for (int i = 0; i < n_prefix; i++) begin
			send_byte(prefix_byte($urandom_range(0, NUM_PREFIXES - 1)), rst);
			rst = 1'b0;
		end
		if ($urandom_range(0, 1)) begin
			send_byte({REX_HI_NIBBLE, 4'($urandom_range(0, 15))}, rst);
			rst = 1'b0;
		end
		op = pick_opcode();
		send_byte(op, rst);
		if (op == OP_ESCAPE_0F)
			send_byte(pick_op2(), 1'b0);
		if (sb.phase == PH_MODRM)
			send_byte(pick_modrm(), 1'b0);
		if (sb.phase == PH_SIB)
			send_byte(pick_sib(), 1'b0);
		while (!sb.idle()) begin
			if (cut_short && $urandom_range(0, 2) == 0) begin
				next_restart = 1'b1;
				break;
			end
			send_byte(8'($urandom), 1'b0);
		end
	endtask

	// Stimulus
	initial begin
		logic [7:0] prologue[$];
		int         pick;
		bit         first_seq;
		bit         hold_done;
		arst_n = 1'b0;
		in_valid = 1'b0;
		code_byte = '0;
		restart = 1'b0;
		first_seq = 1'b1;
		hold_done = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// push rbp; mov rbp,rsp; lea rax,[rip+d32]; sub rsp,imm8;
		// nop [rax+rax+d8]; mov eax,[SIB base 5, mod 0: no disp];
		// REX then a prefix (error); all-ones opcode (error)
		prologue = '{8'h55, 8'h48, 8'h89, 8'hE5,
			8'h48, 8'h8D, 8'h05, 8'h78, 8'h56, 8'h34, 8'h12,
			8'h48, 8'h83, 8'hEC, 8'h28,
			8'h0F, 8'h1F, 8'h44, 8'h00, 8'h00,
			8'h8B, 8'h04, 8'h25,
			8'h48, 8'h66, 8'hFF};
		foreach (prologue[i])
			send_byte(prologue[i], 1'b0);
		// mov eax,imm32 dropped partway by a restart on int3
		send_byte(OP_MOV_RI32, 1'b0);
		send_byte(8'h11, 1'b0);
		send_byte(OP_INT3, 1'b1);

		// Random part, first sequence a long prefix run that can pass saturation
		while (sent_count < ITEM_TARGET) begin
			if (sent_count > ITEM_TARGET - CALM_ITEMS)
				quiet_tail = 1'b1;
			if (!hold_done && sent_count > 150) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (first_seq || pick < 3) begin
				first_seq = 1'b0;
				send_insn($urandom_range(28, 40), 1'b0);
			end else if (pick < 13) begin
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom), $urandom_range(0, 3) == 0);
				next_restart = 1'($urandom_range(0, 1));
			end else if (pick < 23) begin
				send_insn($urandom_range(0, 2), 1'b1);
			end else begin
				send_insn($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0, 1'b0);
			end
		end
		in_valid <= 1'b0;

		// Drain
		while (sb.pending_insns.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0)
			$display("[x64_insn_length_decoder_core] OK");
		else
			$display("[x64_insn_length_decoder_core] ERROR");
		$finish;
	end

	// Sink stall: random bursts, plus one long hold-off
	initial begin
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(insn_length, rip_relative, disp_offset, decode_error);
	end

	// Watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[x64_insn_length_decoder_core] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
